// ===== rtl/hgms_pkg.sv =====
// Shared types and constants of the hypergraph max-sum update block.
`timescale 1ns / 1ps

package hgms_pkg;

    // Node table depth equals the reach of the 10-bit node index field.
    localparam int unsigned NODE_W       = 10;
    localparam int unsigned NODES        = 1 << NODE_W;
    localparam int unsigned SCORE_W      = 32;
    localparam int unsigned EDGE_W       = 8;
    localparam int unsigned SIZE_W       = 3;
    localparam int unsigned CHILD_FIELDS = 4;
    localparam int unsigned MAX_CHILDREN = 4;
    localparam int unsigned MAX_EDGES    = 256;
    localparam int unsigned EDGE_CMP_W   = 13;

    localparam logic [SIZE_W-1:0] CHILD_LIMIT =
        SIZE_W'((MAX_CHILDREN < CHILD_FIELDS) ? MAX_CHILDREN : CHILD_FIELDS);

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

    // Input opcodes
    localparam logic OP_EDGE   = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // One node entry of the table
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [EDGE_W-1:0]         best_edge;
        logic [SIZE_W-1:0]         best_size;
        logic                      removed;
        logic                      seen;
    } t_entry;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

endpackage

// ===== rtl/hypergraph_max_sum_update.sv =====
// Top level: sequencer of the hypergraph max-sum node update.
// Items are handled one at a time: a new item is accepted only after the result of the last
// one is loaded into the result register; the node table has a single read port, so the parent
// and each child are read in turn.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every node table entry,
// during which no beat is accepted.
`timescale 1ns / 1ps

module hypergraph_max_sum_update
    import hgms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata, lowest bit up: parent_node[10], edge_index[8], edge_score[32], child_count[3],
    // child_a[10], child_b[10], child_c[10], child_d[10], zero pad[3]
    input  logic [95:0] i_s_tdata,
    // tuser: opcode[1]
    input  logic        i_s_tuser,
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata, lowest bit up: result_node[10], best_score[32], best_edge[8],
    // best_child_count[3], edge_ignored[1], score_saturated[1], zero pad[1]
    output logic [55:0] o_m_tdata
);

    // Unpack the input beat
    logic [NODE_W-1:0]         w_in_node;
    logic [EDGE_W-1:0]         w_in_edge;
    logic signed [SCORE_W-1:0] w_in_score;
    logic [SIZE_W-1:0]         w_in_count;
    logic [NODE_W-1:0]         w_in_kid [CHILD_FIELDS];

    assign w_in_node   = i_s_tdata[9:0];
    assign w_in_edge   = i_s_tdata[17:10];
    assign w_in_score  = i_s_tdata[49:18];
    assign w_in_count  = i_s_tdata[52:50];
    assign w_in_kid[0] = i_s_tdata[62:53];
    assign w_in_kid[1] = i_s_tdata[72:63];
    assign w_in_kid[2] = i_s_tdata[82:73];
    assign w_in_kid[3] = i_s_tdata[92:83];

    t_state r_state, n_state;

    // Item registers
    logic                      r_op;
    logic [NODE_W-1:0]         r_node;
    logic [EDGE_W-1:0]         r_edge;
    logic [SIZE_W-1:0]         r_cnt;
    logic [NODE_W-1:0]         r_kid [CHILD_FIELDS];
    logic [SIZE_W-1:0]         r_step;
    logic signed [SCORE_W-1:0] r_acc, n_acc;
    logic                      r_sat, n_sat;
    logic                      r_skip, n_skip;
    t_entry                    r_par, n_par;
    logic [NODE_W-1:0]         r_clr_addr;

    // Output register
    logic                      r_out_valid;
    logic [NODE_W-1:0]         r_out_node;
    logic signed [SCORE_W-1:0] r_out_score;
    logic [EDGE_W-1:0]         r_out_edge;
    logic [SIZE_W-1:0]         r_out_size;
    logic                      r_out_ign;
    logic                      r_out_sat;

    // Node table and shared adder
    logic                      w_we;
    logic [NODE_W-1:0]         w_waddr;
    t_entry                    w_wdata;
    logic [NODE_W-1:0]         w_raddr;
    t_entry                    w_rdata;
    logic signed [SCORE_W-1:0] w_sum;
    logic                      w_add_sat;

    logic                      w_accept;
    logic                      w_out_free;
    logic                      w_out_load;
    logic                      w_upd;
    logic [1:0]                w_kid_sel;
    logic [SIZE_W-1:0]         w_last_step;
    logic [SIZE_W-1:0]         w_clamp;

    hgms_node_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    hgms_sat_add u_add (
        .i_a   (r_acc),
        .i_b   (w_rdata.score),
        .o_sum (w_sum),
        .o_sat (w_add_sat)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_clamp     = (w_in_count > CHILD_LIMIT) ? CHILD_LIMIT : w_in_count;
    assign w_last_step = SIZE_W'(r_cnt + SIZE_W'(1));
    // Step s reads child s-1; step 0 reads the parent
    assign w_kid_sel   = 2'(r_step - SIZE_W'(1));
    // A hyperedge replaces the entry when it is the first accepted one or scores higher
    assign w_upd       = !r_par.seen || (r_acc > r_par.score);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == NODE_W'(NODES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) n_state = S_RUN;
            end
            S_RUN: begin
                if (r_step == w_last_step) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Table port control and result load
    always_comb begin
        w_we       = 1'b0;
        w_waddr    = r_node;
        w_wdata    = '0;
        w_raddr    = r_node;
        w_out_load = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
            end
            S_IDLE: begin
                w_raddr = w_in_node;
            end
            S_RUN: begin
                if (r_step != '0) w_raddr = r_kid[w_kid_sel];
            end
            S_DONE: begin
                w_out_load = w_out_free;
                if (r_op == OP_REMOVE) begin
                    w_we    = w_out_free;
                    w_wdata = r_par;
                    w_wdata.score   = SCORE_MIN;
                    w_wdata.removed = 1'b1;
                end else if (!r_skip && w_upd) begin
                    w_we    = w_out_free;
                    w_wdata.score     = r_acc;
                    w_wdata.best_edge = r_edge;
                    w_wdata.best_size = r_cnt;
                    w_wdata.removed   = 1'b0;
                    w_wdata.seen      = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Accumulate over the parent and child reads
    always_comb begin
        n_acc  = r_acc;
        n_sat  = r_sat;
        n_skip = r_skip;
        n_par  = r_par;
        if (w_accept) begin
            n_acc  = w_in_score;
            n_sat  = 1'b0;
            // Leaf parent and out-of-range edge index are known before any read
            n_skip = (w_in_node == '0) ||
                     ({{(EDGE_CMP_W-EDGE_W){1'b0}}, w_in_edge} >= EDGE_CMP_W'(MAX_EDGES));
        end
        if (r_state == S_RUN && r_step != '0) begin
            if (w_rdata.removed) n_skip = 1'b1;
            if (r_step == SIZE_W'(1)) begin
                n_par = w_rdata;
            end else begin
                n_acc = w_sum;
                n_sat = r_sat | w_add_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr_addr <= NODE_W'(r_clr_addr + NODE_W'(1));
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_sat  <= n_sat;
        r_skip <= n_skip;
        r_par  <= n_par;
        if (r_state == S_RUN) r_step <= SIZE_W'(r_step + SIZE_W'(1));
        if (w_accept) begin
            r_op   <= i_s_tuser;
            r_node <= w_in_node;
            r_edge <= w_in_edge;
            r_cnt  <= (i_s_tuser == OP_REMOVE) ? '0 : w_clamp;
            r_kid  <= w_in_kid;
            r_step <= '0;
        end
        if (w_out_load) begin
            r_out_node <= r_node;
            if (r_op == OP_REMOVE) begin
                r_out_score <= SCORE_MIN;
                r_out_edge  <= r_par.best_edge;
                r_out_size  <= r_par.best_size;
                r_out_ign   <= 1'b0;
                r_out_sat   <= 1'b0;
            end else if (r_skip) begin
                r_out_score <= r_par.score;
                r_out_edge  <= r_par.best_edge;
                r_out_size  <= r_par.best_size;
                r_out_ign   <= 1'b1;
                r_out_sat   <= 1'b0;
            end else begin
                r_out_score <= w_upd ? r_acc  : r_par.score;
                r_out_edge  <= w_upd ? r_edge : r_par.best_edge;
                r_out_size  <= w_upd ? r_cnt  : r_par.best_size;
                r_out_ign   <= 1'b0;
                r_out_sat   <= r_sat;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_sat, r_out_ign, r_out_size, r_out_edge,
                         r_out_score, r_out_node};

endmodule

// ===== rtl/hgms_node_ram.sv =====
// Node table: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module hgms_node_ram
    import hgms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [NODE_W-1:0] i_waddr,
    input  t_entry            i_wdata,
    input  logic [NODE_W-1:0] i_raddr,
    output t_entry            o_rdata
);

    t_entry r_mem [NODES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/hgms_sat_add.sv =====
// Saturating signed adder shared by all child score additions.
`timescale 1ns / 1ps

module hgms_sat_add
    import hgms_pkg::*;
(
    input  logic signed [SCORE_W-1:0] i_a,
    input  logic signed [SCORE_W-1:0] i_b,
    output logic signed [SCORE_W-1:0] o_sum,
    output logic                      o_sat
);

    logic signed [SCORE_W:0] w_full;

    always_comb begin
        w_full = {i_a[SCORE_W-1], i_a} + {i_b[SCORE_W-1], i_b};
        // Overflow when the two top bits of the wide sum disagree
        o_sat  = w_full[SCORE_W] ^ w_full[SCORE_W-1];
        if (o_sat) begin
            o_sum = w_full[SCORE_W] ? SCORE_MIN : SCORE_MAX;
        end else begin
            o_sum = w_full[SCORE_W-1:0];
        end
    end

endmodule
